[hdl/vrp_pkg.sv]
// Shared types, register codes and the video memory address map.
package vrp_pkg;

  localparam int DATA_W = 8;
  localparam int REG_W  = 3;
  localparam int VADDR_W = 15;
  localparam int MAP_W   = 14;

  typedef logic [DATA_W-1:0]  byte_t;
  typedef logic [REG_W-1:0]   reg_index_t;
  typedef logic [VADDR_W-1:0] vaddr_t;
  typedef logic [MAP_W-1:0]   map_addr_t;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam reg_index_t REG_CTRL   = 3'd0;
  localparam reg_index_t REG_MASK   = 3'd1;
  localparam reg_index_t REG_STATUS = 3'd2;
  localparam reg_index_t REG_OAMA   = 3'd3;
  localparam reg_index_t REG_OAMD   = 3'd4;
  localparam reg_index_t REG_SCROLL = 3'd5;
  localparam reg_index_t REG_ADDR   = 3'd6;
  localparam reg_index_t REG_DATA   = 3'd7;

  localparam map_addr_t MIRROR_LO    = 14'h3000;
  localparam map_addr_t MIRROR_HI    = 14'h3EFF;
  localparam map_addr_t MIRROR_SHIFT = 14'h1000;
  localparam map_addr_t PALETTE_BASE = 14'h3F00;
  localparam map_addr_t PALETTE_END  = 14'h3F20;

  localparam vaddr_t STEP_ACROSS = 15'd1;
  localparam vaddr_t STEP_DOWN   = 15'd32;

  // Tag carried with a request from the register stage to the result stage.
  typedef struct packed {
    logic  is_data;
    logic  palette;
    byte_t value;
  } rd_tag_t;

  function automatic map_addr_t map_address(input vaddr_t addr);
    map_addr_t a;
    a = addr[MAP_W-1:0];
    if (a >= MIRROR_LO && a <= MIRROR_HI) begin
      return a - MIRROR_SHIFT;
    end else if (a >= PALETTE_END) begin
      return {PALETTE_BASE[MAP_W-1:5], a[4:0]};
    end
    return a;
  endfunction

endpackage

[hdl/vrp_if.sv]
// Request and response channel interfaces.
interface vrp_req_if;
  import vrp_pkg::*;
  logic       valid;
  logic       ready;
  logic       operation;
  reg_index_t reg_index;
  byte_t      write_data;
  modport source (output valid, operation, reg_index, write_data, input ready);
  modport sink (input valid, operation, reg_index, write_data, output ready);
endinterface

interface vrp_rsp_if;
  import vrp_pkg::*;
  logic  valid;
  logic  ready;
  byte_t read_data;
  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

[hdl/vrp_vram.sv]
// Video memory with a clearing sweep after reset and a registered read port.
module vrp_vram #(
  parameter int VRAM_DEPTH = 16384,
  parameter int AW = $clog2(VRAM_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  output logic          busy,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  vrp_pkg::byte_t wdata,
  output vrp_pkg::byte_t rdata
);
  import vrp_pkg::*;

  byte_t         mem [VRAM_DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(VRAM_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[hdl/vrp_regs.sv]
// Register file, scroll/address latches and memory request decode.
module vrp_regs #(
  parameter int AW = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                operation,
  input  vrp_pkg::reg_index_t reg_index,
  input  vrp_pkg::byte_t      write_data,
  output logic                mem_we,
  output logic                mem_re,
  output logic [AW-1:0]       mem_addr,
  output vrp_pkg::rd_tag_t    tag
);
  import vrp_pkg::*;

  byte_t     control_reg;
  byte_t     mask_reg;
  byte_t     status_reg;
  vaddr_t    temp_address;
  vaddr_t    current_address;
  logic [2:0] fine_scroll_x;
  logic      second_write_flag;
  map_addr_t mapped;
  logic      is_data;
  byte_t     reg_value;

  assign mapped   = map_address(current_address);
  assign mem_addr = mapped[AW-1:0];
  assign is_data  = (reg_index == REG_DATA);
  assign mem_we   = accept && (operation == OP_WRITE) && is_data;
  assign mem_re   = accept && (operation == OP_READ) && is_data;

  always_comb begin
    unique case (reg_index)
      REG_CTRL:   reg_value = control_reg;
      REG_MASK:   reg_value = mask_reg;
      REG_STATUS: reg_value = status_reg;
      default:    reg_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag.is_data <= (operation == OP_READ) && is_data;
      tag.palette <= (current_address[MAP_W-1:0] >= PALETTE_BASE);
      tag.value   <= (operation == OP_READ) ? reg_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg       <= '0;
      mask_reg          <= '0;
      status_reg        <= '0;
      temp_address      <= '0;
      current_address   <= '0;
      fine_scroll_x     <= '0;
      second_write_flag <= 1'b0;
    end else if (accept) begin
      if (operation == OP_WRITE) begin
        unique case (reg_index)
          REG_CTRL: begin
            control_reg         <= write_data;
            temp_address[11:10] <= write_data[1:0];
          end
          REG_MASK:   mask_reg   <= write_data;
          REG_STATUS: status_reg <= write_data;
          REG_SCROLL: begin
            if (second_write_flag) begin
              temp_address[14:12] <= write_data[2:0];
              temp_address[9:5]   <= write_data[7:3];
            end else begin
              fine_scroll_x     <= write_data[2:0];
              temp_address[4:0] <= write_data[7:3];
            end
            second_write_flag <= ~second_write_flag;
          end
          REG_ADDR: begin
            if (second_write_flag) begin
              temp_address[7:0] <= write_data;
              current_address   <= {temp_address[14:8], write_data};
            end else begin
              temp_address[14:8] <= {1'b0, write_data[5:0]};
            end
            second_write_flag <= ~second_write_flag;
          end
          REG_DATA: begin
            current_address <= current_address + (control_reg[2] ? STEP_DOWN : STEP_ACROSS);
          end
          default: ;
        endcase
      end else if (reg_index == REG_STATUS) begin
        second_write_flag <= 1'b0;
      end
    end
  end

endmodule

[hdl/video_register_port_with_scroll_latches.sv]
// Top level: video register port with scroll latches and video memory.
//
//   channel | dir | payload                              | request
//   --------+-----+--------------------------------------+---------------------------
//   req     | in  | operation, reg_index, write_data     | one register access
//   rsp     | out | read_data                            | one byte per request
//
// One request per cycle while req.ready is high; its response passes through the
// register stage, then memory read data goes into the result (output register).
// After reset the video memory is swept to zero over all VRAM_DEPTH addresses,
// and req.ready stays low during the sweep. A stalled rsp holds the result stage;
// requests keep flowing while that stage has room.
module video_register_port_with_scroll_latches #(
  parameter int VRAM_DEPTH = 16384
) (
  input logic        clk,
  input logic        rst,
  vrp_req_if.sink    req,
  vrp_rsp_if.source  rsp
);
  import vrp_pkg::*;

  localparam int AW = $clog2(VRAM_DEPTH);

  logic          busy;
  logic          accept;
  logic          out_load;
  logic          s2_valid;
  logic          out_valid;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  byte_t         mem_rdata;
  byte_t         read_buffer;
  byte_t         out_data;
  rd_tag_t       tag;

  assign out_load  = s2_valid && (!out_valid || rsp.ready);
  assign req.ready = !busy && (!s2_valid || out_load);
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.read_data = out_data;

  vrp_regs #(.AW(AW)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (req.operation),
    .reg_index  (req.reg_index),
    .write_data (req.write_data),
    .mem_we     (mem_we),
    .mem_re     (mem_re),
    .mem_addr   (mem_addr),
    .tag        (tag)
  );

  vrp_vram #(.VRAM_DEPTH(VRAM_DEPTH), .AW(AW)) u_vram (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (req.write_data),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid    <= 1'b0;
      out_valid   <= 1'b0;
      read_buffer <= '0;
    end else begin
      s2_valid <= accept || (s2_valid && !out_load);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      // advance the one-behind buffer on every data-port read
      if (out_load && tag.is_data) begin
        read_buffer <= mem_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tag.is_data) begin
        out_data <= tag.palette ? mem_rdata : read_buffer;
      end else begin
        out_data <= tag.value;
      end
    end
  end

endmodule

[verif/tb_video_register_port_with_scroll_latches.sv]
// Testbench for the video register port: directed table, random register traffic, predictor.
module tb_video_register_port_with_scroll_latches;
  timeunit 1ns;
  timeprecision 1ps;
  import vrp_pkg::*;

  localparam int MEM_DEPTH = 16384;
  localparam int RANDOM_ITEMS = 750;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic       op;
    reg_index_t idx;
    byte_t      data;
    logic       checked;
    byte_t      exp;
  } stim_row_t;

  localparam int N_ROWS = 27;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{OP_READ,  REG_CTRL,   8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_MASK,   8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_STATUS, 8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_OAMA,   8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_OAMD,   8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_SCROLL, 8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_ADDR,   8'h00, 1'b1, 8'h00},
    '{OP_READ,  REG_DATA,   8'h00, 1'b1, 8'h00},
    '{OP_WRITE, REG_CTRL,   8'hFF, 1'b1, 8'h00},
    '{OP_READ,  REG_CTRL,   8'h00, 1'b1, 8'hFF},
    '{OP_WRITE, REG_MASK,   8'hFF, 1'b1, 8'h00},
    '{OP_READ,  REG_MASK,   8'h00, 1'b1, 8'hFF},
    '{OP_WRITE, REG_STATUS, 8'h5A, 1'b1, 8'h00},
    '{OP_READ,  REG_STATUS, 8'h00, 1'b1, 8'h5A},
    '{OP_WRITE, REG_OAMA,   8'hFF, 1'b1, 8'h00},
    '{OP_WRITE, REG_OAMD,   8'hFF, 1'b1, 8'h00},
    '{OP_WRITE, REG_CTRL,   8'h00, 1'b1, 8'h00},
    '{OP_WRITE, REG_SCROLL, 8'hFF, 1'b1, 8'h00},
    '{OP_WRITE, REG_SCROLL, 8'h00, 1'b1, 8'h00},
    // top of palette space, then step across into the 15th address bit
    '{OP_WRITE, REG_ADDR,   8'hFF, 1'b1, 8'h00},
    '{OP_WRITE, REG_ADDR,   8'hFF, 1'b1, 8'h00},
    '{OP_WRITE, REG_DATA,   8'h81, 1'b1, 8'h00},
    '{OP_WRITE, REG_DATA,   8'h7E, 1'b1, 8'h00},
    '{OP_READ,  REG_DATA,   8'h00, 1'b0, 8'h00},
    // palette reads bypass the buffer
    '{OP_WRITE, REG_ADDR,   8'h3F, 1'b1, 8'h00},
    '{OP_WRITE, REG_ADDR,   8'h1F, 1'b1, 8'h00},
    '{OP_READ,  REG_DATA,   8'h00, 1'b0, 8'h00}
  };

  logic clk;
  logic rst;

  vrp_req_if req_ch ();
  vrp_rsp_if rsp_ch ();

  video_register_port_with_scroll_latches DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the register file and video memory
  byte_t  ctrl_q;
  byte_t  mask_q;
  byte_t  status_q;
  vaddr_t tmp_addr_q;
  vaddr_t cur_addr_q;
  logic [2:0] fine_x_q;
  logic   toggle_q;
  byte_t  data_buf_q;
  byte_t  vmem_shadow [MEM_DEPTH];

  byte_t pending_read_data [$];
  int    mismatch_count;
  int    items_sent;
  int    send_calm;
  int    sink_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

  function automatic map_addr_t vmem_slot(vaddr_t addr);
    map_addr_t a;
    a = addr[MAP_W-1:0];
    if (a >= MIRROR_LO && a <= MIRROR_HI) begin
      a = a - MIRROR_SHIFT;
    end else if (a >= PALETTE_END) begin
      a = PALETTE_BASE | map_addr_t'(a[4:0]);
    end
    return a;
  endfunction

  // Advance the shadow state by one access and return the byte it yields.
  function automatic byte_t predict_access(logic op, reg_index_t idx, byte_t d);
    byte_t r;
    byte_t fetched;
    r = '0;
    if (op == OP_WRITE) begin
      case (idx)
        REG_CTRL: begin
          ctrl_q = d;
          tmp_addr_q[11:10] = d[1:0];
        end
        REG_MASK:   mask_q = d;
        REG_STATUS: status_q = d;
        REG_SCROLL: begin
          if (toggle_q) begin
            tmp_addr_q[14:12] = d[2:0];
            tmp_addr_q[9:5] = d[7:3];
          end else begin
            fine_x_q = d[2:0];
            tmp_addr_q[4:0] = d[7:3];
          end
          toggle_q = ~toggle_q;
        end
        REG_ADDR: begin
          if (toggle_q) begin
            tmp_addr_q[7:0] = d;
            cur_addr_q = tmp_addr_q;
          end else begin
            tmp_addr_q[14] = 1'b0;
            tmp_addr_q[13:8] = d[5:0];
          end
          toggle_q = ~toggle_q;
        end
        REG_DATA: begin
          vmem_shadow[vmem_slot(cur_addr_q)] = d;
          cur_addr_q = cur_addr_q + (ctrl_q[2] ? STEP_DOWN : STEP_ACROSS);
        end
        default: ;
      endcase
    end else begin
      case (idx)
        REG_CTRL: r = ctrl_q;
        REG_MASK: r = mask_q;
        REG_STATUS: begin
          r = status_q;
          toggle_q = 1'b0;
        end
        REG_DATA: begin
          fetched = vmem_shadow[vmem_slot(cur_addr_q)];
          r = data_buf_q;
          data_buf_q = fetched;
          if (cur_addr_q[MAP_W-1:0] >= PALETTE_BASE) r = fetched;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  task automatic send_access(logic op, reg_index_t idx, byte_t d, logic checked, byte_t exp);
    int gap;
    byte_t pv;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.operation <= op;
    req_ch.reg_index <= idx;
    req_ch.write_data <= d;
    do @(posedge clk); while (!req_ch.ready);
    pv = predict_access(op, idx, d);
    pending_read_data.push_back(checked ? exp : pv);
    items_sent++;
  endtask

  function automatic byte_t pick_addr_hi();
    case ($urandom_range(0, 4))
      0: return byte_t'($urandom_range(0, 255));
      1: return {2'($urandom_range(0, 3)), 6'h3F};
      2: return byte_t'($urandom_range(8'h20, 8'h2F));
      3: return byte_t'($urandom_range(8'h30, 8'h3E));
      default: return byte_t'($urandom_range(8'h00, 8'h1F));
    endcase
  endfunction

  task automatic run_random_traffic();
    int kind;
    int burst;
    while (items_sent < N_ROWS + RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        // well-formed address setup followed by a data burst
        if ($urandom_range(0, 7) != 0)
          send_access(OP_READ, REG_STATUS, byte_t'($urandom_range(0, 255)), 1'b0, '0);
        send_access(OP_WRITE, REG_ADDR, pick_addr_hi(), 1'b0, '0);
        send_access(OP_WRITE, REG_ADDR, byte_t'($urandom_range(0, 255)), 1'b0, '0);
        burst = $urandom_range(1, 8);
        repeat (burst)
          send_access(logic'($urandom_range(0, 1)), REG_DATA,
                      byte_t'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind == 4) begin
        send_access(OP_WRITE, REG_CTRL, byte_t'($urandom_range(0, 255)), 1'b0, '0);
        send_access(OP_READ, REG_CTRL, '0, 1'b0, '0);
      end else if (kind == 5) begin
        send_access(OP_WRITE, REG_SCROLL, byte_t'($urandom_range(0, 255)), 1'b0, '0);
        send_access(OP_WRITE, REG_SCROLL, byte_t'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind == 6) begin
        send_access(OP_WRITE, reg_index_t'($urandom_range(1, 2)),
                    byte_t'($urandom_range(0, 255)), 1'b0, '0);
        send_access(OP_READ, reg_index_t'($urandom_range(1, 2)), '0, 1'b0, '0);
      end else begin
        send_access(logic'($urandom_range(0, 1)), reg_index_t'($urandom_range(0, 7)),
                    byte_t'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  function automatic void check_read_data(byte_t got);
    byte_t want;
    if (pending_read_data.size() == 0) begin
      $error("read_data: expected none, actual %02h", got);
      mismatch_count++;
    end else begin
      want = pending_read_data.pop_front();
      if (got !== want) begin
        $error("read_data: expected %02h, actual %02h", want, got);
        mismatch_count++;
      end
    end
  endfunction

  // Response side: random stalls, check every accepted response.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    sink_calm = 0;
    forever begin
      if (sink_calm > 0) begin
        sink_calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0) sink_calm = $urandom_range(8, 30);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      // valid is unknown until the first reset edge
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      check_read_data(rsp_ch.read_data);
    end
  end

  initial begin
    ctrl_q = '0;
    mask_q = '0;
    status_q = '0;
    tmp_addr_q = '0;
    cur_addr_q = '0;
    fine_x_q = '0;
    toggle_q = 1'b0;
    data_buf_q = '0;
    for (int i = 0; i < MEM_DEPTH; i++) vmem_shadow[i] = '0;
    mismatch_count = 0;
    items_sent = 0;
    send_calm = 0;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.operation <= OP_READ;
    req_ch.reg_index <= REG_CTRL;
    req_ch.write_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      send_access(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].idx, DIRECTED_ROWS[i].data,
                  DIRECTED_ROWS[i].checked, DIRECTED_ROWS[i].exp);
    run_random_traffic();
    req_ch.valid <= 1'b0;

    // drain outstanding responses, then watch for strays
    while (pending_read_data.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_read_data.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/vrp_pkg.sv
hdl/vrp_if.sv
hdl/vrp_vram.sv
hdl/vrp_regs.sv
hdl/video_register_port_with_scroll_latches.sv
verif/tb_video_register_port_with_scroll_latches.sv
